>>> rtl/splitmix64_random_generator_unit_macros.svh
// Assertion macros for the SplitMix64 generator.
// Used by the controller; expects clk_i and rst_ni in scope.
`ifndef SPLITMIX64_RANDOM_GENERATOR_UNIT_MACROS_SVH
`define SPLITMIX64_RANDOM_GENERATOR_UNIT_MACROS_SVH

// Property that must hold on every clock edge outside reset.
`define SM64_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Antecedent in one cycle implies consequent in the next.
`define SM64_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/sm64_pkg.sv
// Shared types and constants of the SplitMix64 generator.
// No dependencies.
package sm64_pkg;

  localparam int unsigned DRAW_W = 64;
  localparam int unsigned FRAC_W = 53;
  localparam int unsigned HALF_W = DRAW_W / 2;
  localparam int unsigned CTR_W  = 6;

  localparam logic [DRAW_W-1:0] GOLDEN_GAMMA = 64'h9E3779B97F4A7C15;
  localparam logic [DRAW_W-1:0] MIX_MUL_A    = 64'hBF58476D1CE4E5B9;
  localparam logic [DRAW_W-1:0] MIX_MUL_B    = 64'h94D049BB133111EB;
  localparam int unsigned SHIFT_A    = 30;
  localparam int unsigned SHIFT_B    = 27;
  localparam int unsigned SHIFT_C    = 31;
  localparam int unsigned FRAC_SHIFT = DRAW_W - FRAC_W;
  localparam logic [16:0] PROB_ONE   = 17'h10000;
  localparam logic [CTR_W-1:0] DIV_LAST = CTR_W'(DRAW_W - 1);
  localparam logic [1:0] MUL_LAST = 2'd2;

  localparam logic [2:0] OP_RAW      = 3'd0;
  localparam logic [2:0] OP_FRACTION = 3'd1;
  localparam logic [2:0] OP_RANGED   = 3'd2;
  localparam logic [2:0] OP_FLAG     = 3'd3;
  localparam logic [2:0] OP_RESEED   = 3'd4;

  typedef struct packed {
    logic [2:0]         op;
    logic signed [31:0] range_low;
    logic signed [31:0] range_high;
    logic [16:0]        probability;
    logic [63:0]        seed_value;
  } in_item_t;

  typedef struct packed {
    logic [63:0]        raw_value;
    logic [52:0]        fraction;
    logic signed [31:0] ranged_value;
    logic               flag;
    logic               drew;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_ADV,
    ST_X30,
    ST_MUL1,
    ST_X27,
    ST_MUL2,
    ST_X31,
    ST_DIV,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic       capture;
    logic       reseed;
    logic       advance;
    logic       xs30;
    logic       mul_en;
    logic       mul_sel_b;
    logic [1:0] mul_phase;
    logic       xs27;
    logic       xs31;
    logic       div_step;
    logic       out_load;
  } cmd_t;

  typedef struct packed {
    logic needs_draw;
    logic is_ranged;
    logic is_reseed;
  } status_t;

endpackage

>>> rtl/splitmix64_random_generator_unit.sv
// SplitMix64 generator, one transaction at a time.
// A draw advances the state and mixes it; a ranged draw adds a 64-step radix-2
// remainder; a reseed or an op without a draw does neither.
// A new transaction is taken once the last result is loaded; the result register frees input.
// Reset clears the generator state to zero and empties the result register.
module splitmix64_random_generator_unit
  import sm64_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_item_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_data_o
);

  cmd_t    cmd;
  status_t status;

  sm64_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  sm64_dpath u_dpath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_data_i  (in_data_i),
    .cmd_i      (cmd),
    .status_o   (status),
    .out_data_o (out_data_o)
  );

endmodule

>>> rtl/sm64_ctrl.sv
// Sequencing state machine of the SplitMix64 generator.
// Depends on sm64_pkg and the assertion macro header.
`include "splitmix64_random_generator_unit_macros.svh"

module sm64_ctrl
  import sm64_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  output logic    out_valid_o,
  input  logic    out_ready_i,
  input  status_t status_i,
  output cmd_t    cmd_o
);

  state_e           state_q, state_d;
  logic [CTR_W-1:0] ctr_q, ctr_d;
  logic             out_valid_q, out_valid_d;
  logic             slot_free;

  assign slot_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d = state_q;
    ctr_d   = ctr_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_DECIDE;
      end
      ST_DECIDE: begin
        if (status_i.is_reseed) state_d = ST_DONE;
        else if (status_i.needs_draw) state_d = ST_ADV;
        else state_d = ST_DONE;
      end
      ST_ADV: state_d = ST_X30;
      ST_X30: begin
        state_d = ST_MUL1;
        ctr_d   = '0;
      end
      ST_MUL1: begin
        ctr_d = ctr_q + 1'b1;
        if (ctr_q[1:0] == MUL_LAST) state_d = ST_X27;
      end
      ST_X27: begin
        state_d = ST_MUL2;
        ctr_d   = '0;
      end
      ST_MUL2: begin
        ctr_d = ctr_q + 1'b1;
        if (ctr_q[1:0] == MUL_LAST) state_d = ST_X31;
      end
      ST_X31: begin
        ctr_d   = '0;
        state_d = status_i.is_ranged ? ST_DIV : ST_DONE;
      end
      ST_DIV: begin
        ctr_d = ctr_q + 1'b1;
        if (ctr_q == DIV_LAST) state_d = ST_DONE;
      end
      ST_DONE: begin
        if (slot_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.capture = in_valid_i;
      end
      ST_DECIDE: cmd_o.reseed = status_i.is_reseed;
      ST_ADV:    cmd_o.advance = 1'b1;
      ST_X30:    cmd_o.xs30 = 1'b1;
      ST_MUL1: begin
        cmd_o.mul_en    = 1'b1;
        cmd_o.mul_phase = ctr_q[1:0];
      end
      ST_X27: cmd_o.xs27 = 1'b1;
      ST_MUL2: begin
        cmd_o.mul_en    = 1'b1;
        cmd_o.mul_sel_b = 1'b1;
        cmd_o.mul_phase = ctr_q[1:0];
      end
      ST_X31:  cmd_o.xs31 = 1'b1;
      ST_DIV:  cmd_o.div_step = 1'b1;
      ST_DONE: cmd_o.out_load = slot_free;
      default: cmd_o = '0;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_ready_i) out_valid_d = 1'b0;
    if (cmd_o.out_load) out_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      ctr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      ctr_q       <= ctr_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  `SM64_ASSERT_NEXT(a_accept_decides, in_valid_i && in_ready_o, state_q == ST_DECIDE, "accept did not start decode")
  `SM64_ASSERT(a_load_slot_free, !cmd_o.out_load || !out_valid_q || out_ready_i, "result overwritten")
  `SM64_ASSERT(a_mul_phase_range, !cmd_o.mul_en || cmd_o.mul_phase != 2'd3, "bad multiply phase")
  `SM64_ASSERT_NEXT(a_div_ends, state_q == ST_DIV && ctr_q == DIV_LAST, state_q == ST_DONE, "divider overran")

endmodule

>>> rtl/sm64_dpath.sv
// Datapath of the SplitMix64 generator: state, mixer, shared multiplier, divider.
// Depends on sm64_pkg.
module sm64_dpath
  import sm64_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  in_item_t  in_data_i,
  input  cmd_t      cmd_i,
  output status_t   status_o,
  output out_item_t out_data_o
);

  in_item_t            item_q;
  logic [DRAW_W-1:0]   gen_q, gen_d;
  logic [DRAW_W-1:0]   z_q, z_d;
  logic [DRAW_W-1:0]   acc_q, acc_d;
  logic [DRAW_W-1:0]   dvd_q, dvd_d;
  logic [32:0]         rem_q, rem_d;
  out_item_t           out_q, out_d;

  logic [HALF_W-1:0]   mul_a, mul_b;
  logic [DRAW_W-1:0]   mul_c, prod;
  logic [DRAW_W-1:0]   gen_next;
  logic [32:0]         span;
  logic [33:0]         rem_sh;
  logic                lo_lt_hi, prob_mid, flag_cmp;

  // status decode from the captured transaction
  assign lo_lt_hi = item_q.range_low < item_q.range_high;
  assign prob_mid = (item_q.probability != '0) && (item_q.probability < PROB_ONE);
  assign status_o.is_reseed  = item_q.op == OP_RESEED;
  assign status_o.is_ranged  = (item_q.op == OP_RANGED) && lo_lt_hi;
  assign status_o.needs_draw = (item_q.op == OP_RAW) || (item_q.op == OP_FRACTION) ||
                               status_o.is_ranged || ((item_q.op == OP_FLAG) && prob_mid);

  assign span = {item_q.range_high[31], item_q.range_high}
              - {item_q.range_low[31], item_q.range_low} + 33'd1;

  assign gen_next = gen_q + GOLDEN_GAMMA;

  // 64x64 low product from three 32x32 partial products
  assign mul_c = cmd_i.mul_sel_b ? MIX_MUL_B : MIX_MUL_A;
  assign mul_a = (cmd_i.mul_phase == MUL_LAST) ? z_q[DRAW_W-1:HALF_W] : z_q[HALF_W-1:0];
  assign mul_b = (cmd_i.mul_phase == 2'd1) ? mul_c[DRAW_W-1:HALF_W] : mul_c[HALF_W-1:0];
  assign prod  = {{HALF_W{1'b0}}, mul_a} * {{HALF_W{1'b0}}, mul_b};

  always_comb begin
    acc_d = acc_q;
    if (cmd_i.mul_en) begin
      case (cmd_i.mul_phase)
        2'd0:    acc_d = prod;
        default: acc_d = acc_q + {prod[HALF_W-1:0], {HALF_W{1'b0}}};
      endcase
    end
  end

  assign rem_sh = {rem_q, dvd_q[DRAW_W-1]};

  always_comb begin
    gen_d = gen_q;
    z_d   = z_q;
    dvd_d = dvd_q;
    rem_d = rem_q;
    if (cmd_i.reseed)  gen_d = item_q.seed_value;
    if (cmd_i.advance) begin
      gen_d = gen_next;
      z_d   = gen_next;
    end
    if (cmd_i.xs30) z_d = z_q ^ (z_q >> SHIFT_A);
    if (cmd_i.xs27) z_d = acc_q ^ (acc_q >> SHIFT_B);
    if (cmd_i.xs31) begin
      z_d   = acc_q ^ (acc_q >> SHIFT_C);
      dvd_d = z_d;
      rem_d = '0;
    end
    if (cmd_i.div_step) begin
      dvd_d = {dvd_q[DRAW_W-2:0], 1'b0};
      if (rem_sh >= {1'b0, span}) rem_d = 33'(rem_sh - {1'b0, span});
      else rem_d = rem_sh[32:0];
    end
  end

  assign flag_cmp = z_q[DRAW_W-1:FRAC_SHIFT] < {item_q.probability[15:0], 37'd0};

  always_comb begin
    out_d      = '0;
    out_d.drew = status_o.needs_draw;
    if (status_o.needs_draw) begin
      out_d.raw_value = z_q;
      out_d.fraction  = z_q[DRAW_W-1:FRAC_SHIFT];
    end
    if (item_q.op == OP_RANGED) begin
      out_d.ranged_value = lo_lt_hi ? item_q.range_low + $signed(rem_q[31:0])
                                    : item_q.range_low;
    end
    if (item_q.op == OP_FLAG) begin
      out_d.flag = prob_mid ? flag_cmp : (item_q.probability != '0);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gen_q <= '0;
    end else begin
      gen_q <= gen_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture)  item_q <= in_data_i;
    if (cmd_i.out_load) out_q  <= out_d;
    z_q   <= z_d;
    acc_q <= acc_d;
    dvd_q <= dvd_d;
    rem_q <= rem_d;
  end

  assign out_data_o = out_q;

endmodule

>>> test/tb_splitmix64_random_generator_unit.sv
// Self-checking testbench for the SplitMix64 generator unit: directed table, then random ops.
// Checked vs an in-bench draw predictor or typed row values; depends on sm64_pkg and the RTL.
`timescale 1ns / 100ps

module tb_splitmix64_random_generator_unit
  import sm64_pkg::*;
();

  localparam logic [2:0] OP_SPARE_A = 3'd5;
  localparam logic [2:0] OP_SPARE_B = 3'd6;
  localparam logic [2:0] OP_SPARE_C = 3'd7;
  localparam logic signed [31:0] INT_MIN = 32'sh8000_0000;
  localparam logic signed [31:0] INT_MAX = 32'sh7fff_ffff;
  localparam int unsigned PROB_SHIFT = FRAC_W - 16;
  localparam int RANDOM_ITEMS = 1750;
  localparam int MAX_IDLE = 4;
  localparam int HOLD_AT = 400;
  localparam int HOLD_CYCLES = 300;
  localparam int DRAIN_CYCLES = 100;
  localparam int REPORT_LIMIT = 10;

  typedef struct {
    in_item_t  stim;
    bit        typed;
    out_item_t want;
  } dir_row_t;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      in_valid_i = 1'b0;
  logic      in_ready_o;
  in_item_t  in_data_i = '0;
  logic      out_valid_o;
  logic      out_ready_i = 1'b0;
  out_item_t out_data_o;

  logic [63:0] gen_state = '0;
  out_item_t   pending_results[$];
  dir_row_t    dir_rows[$];
  int          err_count = 0;
  int          tx_count = 0;
  int          rx_count = 0;

  splitmix64_random_generator_unit uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  initial begin
    #10_000_000;
    $display("splitmix64_random_generator_unit: mismatch");
    $finish;
  end

  function automatic logic [63:0] next_draw();
    logic [63:0] z;
    gen_state = gen_state + GOLDEN_GAMMA;
    z = gen_state;
    z = (z ^ (z >> SHIFT_A)) * MIX_MUL_A;
    z = (z ^ (z >> SHIFT_B)) * MIX_MUL_B;
    return z ^ (z >> SHIFT_C);
  endfunction

  function automatic out_item_t predict_result(in_item_t it);
    out_item_t r;
    logic signed [31:0] lo;
    logic signed [31:0] hi;
    logic [32:0] span;
    logic [63:0] rem;
    r = '0;
    lo = it.range_low;
    hi = it.range_high;
    case (it.op)
      OP_RAW, OP_FRACTION: begin
        r.raw_value = next_draw();
        r.drew = 1'b1;
      end
      OP_RANGED: begin
        if (lo >= hi) begin
          r.ranged_value = lo;
        end else begin
          span = {hi[31], hi} - {lo[31], lo} + 33'd1;
          r.raw_value = next_draw();
          r.drew = 1'b1;
          rem = r.raw_value % {31'd0, span};
          r.ranged_value = lo + rem[31:0];
        end
      end
      OP_FLAG: begin
        if (it.probability == '0) begin
          r.flag = 1'b0;
        end else if (it.probability >= PROB_ONE) begin
          r.flag = 1'b1;
        end else begin
          r.raw_value = next_draw();
          r.drew = 1'b1;
          r.flag = (r.raw_value >> FRAC_SHIFT) < ({47'd0, it.probability} << PROB_SHIFT);
        end
      end
      OP_RESEED: gen_state = it.seed_value;
      default: ;
    endcase
    if (r.drew) r.fraction = FRAC_W'(r.raw_value >> FRAC_SHIFT);
    return r;
  endfunction

  task automatic add_row(input logic [2:0] op, input logic [31:0] lo, input logic [31:0] hi,
                         input logic [16:0] prob, input logic [63:0] seed, input bit typed,
                         input logic [31:0] ranged, input logic flag);
    dir_row_t row;
    row.stim = '{op: op, range_low: lo, range_high: hi, probability: prob, seed_value: seed};
    row.typed = typed;
    row.want = '{raw_value: '0, fraction: '0, ranged_value: ranged, flag: flag, drew: 1'b0};
    dir_rows.insert(dir_rows.size(), row);
  endtask

  function automatic in_item_t random_item();
    in_item_t it;
    int pick;
    it.op = OP_RAW;
    it.range_low = $urandom;
    it.range_high = $urandom;
    it.probability = 17'($urandom_range(0, 17'h1ffff));
    it.seed_value = {$urandom, $urandom};
    pick = $urandom_range(0, 99);
    if (pick < 15) begin
      it.op = OP_RAW;
    end else if (pick < 30) begin
      it.op = OP_FRACTION;
    end else if (pick < 55) begin
      it.op = OP_RANGED;
      case ($urandom_range(0, 3))
        0: it.range_high = it.range_low + $urandom_range(1, 20);
        1: it.range_high = it.range_low + $urandom_range(1, 1000);
        2: it.range_high = it.range_low - $urandom_range(0, 3);
        default: ;
      endcase
    end else if (pick < 80) begin
      it.op = OP_FLAG;
      case ($urandom_range(0, 7))
        0: it.probability = '0;
        1: it.probability = PROB_ONE;
        2: ;
        default: it.probability = 17'($urandom_range(1, 65535));
      endcase
    end else if (pick < 88) begin
      it.op = OP_RESEED;
    end else if (pick < 93) begin
      it.op = 3'($urandom_range(OP_SPARE_A, OP_SPARE_C));
    end else begin
      it.op = 3'($urandom_range(0, 7));
    end
    return it;
  endfunction

  task automatic send_item(input in_item_t it, input bit typed, input out_item_t typed_want);
    int gap;
    bit rdy;
    out_item_t want;
    gap = (((tx_count / 128) % 4) == 3) ? 0 : $urandom_range(0, MAX_IDLE);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    do begin
      @(negedge clk_i);
      rdy = in_ready_o;
      @(posedge clk_i);
    end while (!rdy);
    want = predict_result(it);
    if (typed) want = typed_want;
    pending_results.insert(pending_results.size(), want);
    tx_count++;
  endtask

  task automatic check_result(input out_item_t got);
    out_item_t want;
    if (pending_results.size() == 0) begin
      err_count++;
      if (err_count <= REPORT_LIMIT)
        $display("result %0d unexpected: raw %h frac %h ranged %h flag %b drew %b", rx_count,
                 got.raw_value, got.fraction, got.ranged_value, got.flag, got.drew);
    end else begin
      want = pending_results.pop_front();
      if (got.raw_value !== want.raw_value || got.fraction !== want.fraction ||
          got.ranged_value !== want.ranged_value || got.flag !== want.flag ||
          got.drew !== want.drew) begin
        err_count++;
        if (err_count <= REPORT_LIMIT) begin
          $display("result %0d exp: raw %h frac %h ranged %h flag %b drew %b", rx_count,
                   want.raw_value, want.fraction, want.ranged_value, want.flag, want.drew);
          $display("result %0d got: raw %h frac %h ranged %h flag %b drew %b", rx_count,
                   got.raw_value, got.fraction, got.ranged_value, got.flag, got.drew);
        end
      end
    end
  endtask

  // receiver, with one long hold-off to back up the input side
  initial begin
    int gap;
    bit vld;
    out_item_t got;
    while (!rst_ni) @(posedge clk_i);
    forever begin
      gap = (((rx_count / 100) % 5) == 2) ? 0 : $urandom_range(0, MAX_IDLE);
      if (rx_count == HOLD_AT) gap = HOLD_CYCLES;
      if (gap > 0) begin
        out_ready_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do begin
        @(negedge clk_i);
        vld = out_valid_o;
        got = out_data_o;
        @(posedge clk_i);
      end while (!vld);
      check_result(got);
      rx_count++;
    end
  end

  initial begin
    in_item_t it;
    add_row(OP_RAW,      '0, '0, '0, '0, 1'b0, '0, 1'b0);
    add_row(OP_FRACTION, '0, '0, '0, '0, 1'b0, '0, 1'b0);
    add_row(OP_RANGED,   '0, '0, '0, '0, 1'b1, '0, 1'b0);
    add_row(OP_RANGED,   INT_MAX, INT_MIN, '0, '0, 1'b1, INT_MAX, 1'b0);
    add_row(OP_RANGED,   INT_MIN, INT_MAX, '1, '1, 1'b0, '0, 1'b0);
    add_row(OP_RANGED,   -32'sd1, 32'sd0, '0, '0, 1'b0, '0, 1'b0);
    add_row(OP_RANGED,   INT_MAX - 1, INT_MAX, '0, '0, 1'b0, '0, 1'b0);
    add_row(OP_RANGED,   INT_MIN, INT_MIN + 1, '0, '0, 1'b0, '0, 1'b0);
    add_row(OP_RANGED,   INT_MIN, INT_MIN, '0, '0, 1'b1, INT_MIN, 1'b0);
    add_row(OP_FLAG,     '1, '1, 17'd0, '1, 1'b1, '0, 1'b0);
    add_row(OP_FLAG,     '0, '0, PROB_ONE, '0, 1'b1, '0, 1'b1);
    add_row(OP_FLAG,     '0, '0, PROB_ONE + 17'd1, '0, 1'b1, '0, 1'b1);
    add_row(OP_FLAG,     '0, '0, 17'h1ffff, '0, 1'b1, '0, 1'b1);
    add_row(OP_FLAG,     '0, '0, 17'd1, '0, 1'b0, '0, 1'b0);
    add_row(OP_FLAG,     '0, '0, 17'hffff, '0, 1'b0, '0, 1'b0);
    add_row(OP_RESEED,   '0, '0, '0, '1, 1'b1, '0, 1'b0);
    add_row(OP_RAW,      '0, '0, '0, '0, 1'b0, '0, 1'b0);
    add_row(OP_RESEED,   '1, '1, '1, '0, 1'b1, '0, 1'b0);
    add_row(OP_FRACTION, '1, '1, '1, '1, 1'b0, '0, 1'b0);
    add_row(OP_RESEED,   '0, '0, '0, 64'h8000_0000_0000_0000, 1'b1, '0, 1'b0);
    add_row(OP_SPARE_A,  '1, '1, '1, '1, 1'b1, '0, 1'b0);
    add_row(OP_SPARE_B,  '1, '1, '1, '1, 1'b1, '0, 1'b0);
    add_row(OP_SPARE_C,  '1, '1, '1, '1, 1'b1, '0, 1'b0);
    add_row(OP_RAW,      '0, '0, '0, '0, 1'b0, '0, 1'b0);

    while (!rst_ni) @(posedge clk_i);
    @(posedge clk_i);
    foreach (dir_rows[i]) send_item(dir_rows[i].stim, dir_rows[i].typed, dir_rows[i].want);
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      it = random_item();
      send_item(it, 1'b0, '0);
    end
    in_valid_i <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (err_count == 0 && pending_results.size() == 0) begin
      $display("splitmix64_random_generator_unit: match");
    end else begin
      $display("splitmix64_random_generator_unit: mismatch");
    end
    $finish;
  end

endmodule

>>> sim.f
+incdir+rtl
rtl/sm64_pkg.sv
rtl/sm64_ctrl.sv
rtl/sm64_dpath.sv
rtl/splitmix64_random_generator_unit.sv
test/tb_splitmix64_random_generator_unit.sv
